// ===== rtl/tdr_pkg.sv =====
// Shared codes, descriptor constants and controller/datapath handshake types.
package tdr_pkg;

    // Action codes on the request channel
    localparam logic [1:0] ACT_SUBMIT    = 2'd0;
    localparam logic [1:0] ACT_MARK_DONE = 2'd1;
    localparam logic [1:0] ACT_RECLAIM   = 2'd2;

    // Status codes on the response channel
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RECLAIM  = 3'd2;
    localparam logic [2:0] ST_NOTHING  = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // Descriptor command bits
    localparam logic [7:0] CMD_RS   = 8'h08;
    localparam logic [7:0] CMD_IFCS = 8'h02;
    localparam logic [7:0] CMD_TEOP = 8'h01;
    localparam logic [7:0] DESC_CMD = CMD_RS | CMD_IFCS | CMD_TEOP;

    typedef struct packed {
        logic clear_en;
        logic in_ready;
        logic tag_rd;
        logic exec_commit;
        logic reclaim_issue;
        logic fetch_commit;
    } tdr_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       req_valid;
        logic [1:0] action;
        logic       reclaim_hit;
        logic       out_free;
    } tdr_sts_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  slot;
        logic [31:0] desc_address;
        logic [15:0] desc_length;
        logic [7:0]  desc_command;
        logic [6:0]  tail_index;
        logic [6:0]  head_index;
        logic [15:0] freed_tag;
        logic        freed_tag_valid;
        logic        more_ready;
    } tdr_result_t;

endpackage

// ===== rtl/tdr_if.sv =====
// Request and response channel interfaces.
interface tdr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] buffer_address;
    logic [15:0] frame_length;
    logic [15:0] buffer_tag;
    logic [6:0]  done_slot;

    modport source (
        output valid, action, buffer_address, frame_length, buffer_tag, done_slot,
        input  ready
    );
    modport sink (
        input  valid, action, buffer_address, frame_length, buffer_tag, done_slot,
        output ready
    );
endinterface

interface tdr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [31:0] desc_address;
    logic [15:0] desc_length;
    logic [7:0]  desc_command;
    logic [6:0]  tail_index;
    logic [6:0]  head_index;
    logic [15:0] freed_tag;
    logic        freed_tag_valid;
    logic        more_ready;

    modport source (
        output valid, status, slot, desc_address, desc_length, desc_command,
               tail_index, head_index, freed_tag, freed_tag_valid, more_ready,
        input  ready
    );
    modport sink (
        input  valid, status, slot, desc_address, desc_length, desc_command,
               tail_index, head_index, freed_tag, freed_tag_valid, more_ready,
        output ready
    );
endinterface

// ===== rtl/tdr_ctrl.sv =====
// Sequencer for clearing pass, request execution and reclaim fetch.
module tdr_ctrl
    import tdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tdr_sts_t sts,
    output tdr_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.tag_rd   = 1'b1;
                if (sts.req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // a reclaim hit frees the slot now and reports after the next read
                if (sts.action == ACT_RECLAIM && sts.reclaim_hit)
                begin
                    cmd.reclaim_issue = 1'b1;
                    state_next        = S_FETCH;
                end
                else if (sts.out_free)
                begin
                    cmd.exec_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (sts.out_free)
                begin
                    cmd.fetch_commit = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_fetch_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch_commit |-> ($past(cmd.reclaim_issue) || $past(state_reg == S_FETCH)))
        else $error("reclaim report without a preceding slot free");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.in_ready)
        else $error("request taken while a transaction is in flight");

endmodule

// ===== rtl/tdr_datapath.sv =====
// Ring pointers, slot memories, request latch and response register.
module tdr_datapath
    import tdr_pkg::*;
#(
    parameter int RING_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    tdr_req_if.sink    req,
    tdr_rsp_if.source  rsp,
    input  tdr_cmd_t   cmd,
    output tdr_sts_t   sts
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    typedef logic [PTR_W-1:0] ptr_t;

    function automatic ptr_t ring_next(input ptr_t idx);
        return (idx == LAST_IDX) ? '0 : ptr_t'(idx + 1'b1);
    endfunction

    // control state
    ptr_t        head_reg, head_next;
    ptr_t        tail_reg, tail_next;
    ptr_t        clr_cnt_reg;
    logic        nh_done_reg, nh_done_next;
    logic        out_valid_reg;

    // latched request
    logic [1:0]  act_reg;
    logic [31:0] addr_reg;
    logic [15:0] len_reg;
    logic [15:0] tag_reg;
    logic [6:0]  dslot_reg;

    tdr_result_t out_reg, res;

    // slot stores
    logic [15:0] tag_mem  [RING_DEPTH];
    logic        hb_mem   [RING_DEPTH];
    logic        done_mem [RING_DEPTH];
    logic [15:0] tag_q;
    logic        hb_q;
    logic        done_q;

    logic        tag_we;
    logic        hb_we, hb_wdata;
    logic        done_we, done_wdata;
    ptr_t        hb_waddr, done_waddr;

    ptr_t        nh, nnh, tail_nx, dslot_idx;
    logic        ring_full, dslot_ok, out_load, req_fire;

    assign nh        = ring_next(head_reg);
    assign nnh       = ring_next(nh);
    assign tail_nx   = ring_next(tail_reg);
    assign ring_full = (tail_nx == head_reg);
    assign dslot_ok  = ({25'd0, dslot_reg} < 32'(RING_DEPTH));
    assign dslot_idx = PTR_W'(dslot_reg);
    assign out_load  = cmd.exec_commit | cmd.fetch_commit;
    assign req_fire  = req.valid & req.ready;

    assign req.ready       = cmd.in_ready;
    assign sts.clear_last  = (clr_cnt_reg == LAST_IDX);
    assign sts.req_valid   = req.valid;
    assign sts.action      = act_reg;
    assign sts.reclaim_hit = nh_done_reg;
    assign sts.out_free    = !out_valid_reg || rsp.ready;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        nh_done_next = nh_done_reg;
        tag_we       = 1'b0;
        hb_we        = 1'b0;
        hb_waddr     = clr_cnt_reg;
        hb_wdata     = 1'b0;
        done_we      = 1'b0;
        done_waddr   = clr_cnt_reg;
        done_wdata   = 1'b0;

        res            = '0;
        res.status     = ST_NOTHING;
        res.tail_index = 7'(tail_reg);
        res.head_index = 7'(head_reg);

        if (cmd.clear_en)
        begin
            hb_we   = 1'b1;
            done_we = 1'b1;
        end

        if (cmd.exec_commit)
        begin
            case (act_reg)
                ACT_SUBMIT:
                begin
                    if (ring_full)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        res.status       = ST_ACCEPTED;
                        res.slot         = 7'(tail_reg);
                        res.desc_address = addr_reg;
                        res.desc_length  = len_reg;
                        res.desc_command = DESC_CMD;
                        res.tail_index   = 7'(tail_nx);
                        tag_we           = 1'b1;
                        hb_we            = 1'b1;
                        hb_waddr         = tail_reg;
                        hb_wdata         = 1'b1;
                        done_we          = 1'b1;
                        done_waddr       = tail_reg;
                        done_wdata       = 1'b0;
                        tail_next        = tail_nx;
                        if (tail_reg == nh)
                        begin
                            nh_done_next = 1'b0;
                        end
                    end
                end
                ACT_MARK_DONE:
                begin
                    res.status = ST_DONE;
                    res.slot   = dslot_reg;
                    // ignore slots beyond the ring
                    if (dslot_ok)
                    begin
                        done_we    = 1'b1;
                        done_waddr = dslot_idx;
                        done_wdata = 1'b1;
                        if (dslot_idx == nh)
                        begin
                            nh_done_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res.status = ST_NOTHING;
                end
            endcase
            res.more_ready = nh_done_next;
        end

        if (cmd.reclaim_issue)
        begin
            hb_we      = 1'b1;
            hb_waddr   = nh;
            hb_wdata   = 1'b0;
            done_we    = 1'b1;
            done_waddr = nh;
            done_wdata = 1'b0;
        end

        if (cmd.fetch_commit)
        begin
            res.status          = ST_RECLAIM;
            res.slot            = 7'(nh);
            res.head_index      = 7'(nh);
            res.freed_tag       = hb_q ? tag_q : 16'd0;
            res.freed_tag_valid = hb_q;
            res.more_ready      = done_q;
            head_next           = nh;
            nh_done_next        = done_q;
        end
    end

    // slot memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tail_reg] <= tag_reg;
        end
        if (cmd.tag_rd)
        begin
            tag_q <= tag_mem[nh];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hb_we)
        begin
            hb_mem[hb_waddr] <= hb_wdata;
        end
        if (cmd.tag_rd)
        begin
            hb_q <= hb_mem[nh];
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_we)
        begin
            done_mem[done_waddr] <= done_wdata;
        end
        // done bit of the slot beyond the one being freed
        if (cmd.reclaim_issue)
        begin
            done_q <= done_mem[nnh];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg   <= req.action;
            addr_reg  <= req.buffer_address;
            len_reg   <= req.frame_length;
            tag_reg   <= req.buffer_tag;
            dslot_reg <= req.done_slot;
        end
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= LAST_IDX;
            tail_reg      <= '0;
            clr_cnt_reg   <= '0;
            nh_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            nh_done_reg <= nh_done_next;
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= ptr_t'(clr_cnt_reg + 1'b1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.slot            = out_reg.slot;
    assign rsp.desc_address    = out_reg.desc_address;
    assign rsp.desc_length     = out_reg.desc_length;
    assign rsp.desc_command    = out_reg.desc_command;
    assign rsp.tail_index      = out_reg.tail_index;
    assign rsp.head_index      = out_reg.head_index;
    assign rsp.freed_tag       = out_reg.freed_tag;
    assign rsp.freed_tag_valid = out_reg.freed_tag_valid;
    assign rsp.more_ready      = out_reg.more_ready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && !rsp.ready))
        else $error("response register overwritten while stalled");

    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec_commit |=> $stable(tail_reg))
        else $error("tail moved outside a submit commit");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.fetch_commit |=> $stable(head_reg))
        else $error("head moved outside a reclaim commit");

endmodule

// ===== rtl/tx_descriptor_ring.sv =====
// Transmit descriptor ring manager: one request in, one response out.
//
// The req channel carries one action per transaction: submit a frame, record a
// slot as transmitted by the device, or reclaim the next completed slot. Each
// accepted request yields exactly one transaction on the rsp channel with the
// status, the descriptor words on a submit, the new tail (doorbell) and head,
// the freed buffer tag on a reclaim, and whether the next slot is done.
//
// Requests are handled one at a time: submit, mark-done and a reclaim that finds
// nothing load the response from the EXEC state; a reclaim that frees a slot
// frees it in EXEC and loads the response from the FETCH state, because the
// done bit of the slot after the new head needs a second registered read.
//
// After reset the flag memories are cleared one slot per cycle, all RING_DEPTH
// slots, while req.ready stays low. Tag storage is not cleared.
// A registered response stage parts the channels: while rsp is stalled the
// response holds, a new request is still taken, and it waits in the EXEC or
// FETCH state until the response register frees.
module tx_descriptor_ring
    import tdr_pkg::*;
#(
    parameter int RING_DEPTH = 128
)
(
    input  logic      clk,
    input  logic      rst_n,
    tdr_req_if.sink   req,
    tdr_rsp_if.source rsp
);

    tdr_cmd_t cmd;
    tdr_sts_t sts;

    tdr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    tdr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// ===== test/tx_descriptor_ring_test.sv =====
// Self-checking testbench for the transmit descriptor ring manager.
module tx_descriptor_ring_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdr_pkg::*;

    localparam int RING_DEPTH = 128;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int GEN_COPY = 0;
    localparam int CHK_COPY = 1;
    localparam int TARGET_ITEMS = 2000;
    localparam int QUIET_TAIL = 300;
    localparam int MAX_FILLS = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] buffer_address;
        logic [15:0] frame_length;
        logic [15:0] buffer_tag;
        logic [6:0]  done_slot;
    } ring_req_t;

    logic clk;
    logic rst_n = 1'b0;

    ring_req_t drv_req   = '0;
    logic      drv_valid = 1'b0;
    logic      drv_ready = 1'b0;

    tdr_req_if req_ch();
    tdr_rsp_if rsp_ch();

    assign req_ch.valid          = drv_valid;
    assign req_ch.action         = drv_req.action;
    assign req_ch.buffer_address = drv_req.buffer_address;
    assign req_ch.frame_length   = drv_req.frame_length;
    assign req_ch.buffer_tag     = drv_req.buffer_tag;
    assign req_ch.done_slot      = drv_req.done_slot;
    assign rsp_ch.ready          = drv_ready;

    tx_descriptor_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Two copies of the ring state: one steers generation, one predicts responses
    logic [15:0] ring_tag  [2][RING_DEPTH];
    bit          ring_busy [2][RING_DEPTH];
    bit          ring_done [2][RING_DEPTH];
    logic [6:0]  ring_head [2];
    logic [6:0]  ring_tail [2];

    ring_req_t   ring_requests[$];
    tdr_result_t responses_due[$];

    int unsigned gen_items    = 0;
    int unsigned fills        = 0;
    int unsigned req_total    = 0;
    int unsigned req_accepted = 0;
    int unsigned rsp_accepted = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;

    function automatic logic [6:0] slot_after(logic [6:0] idx);
        return (int'(idx) == RING_DEPTH - 1) ? 7'd0 : idx + 7'd1;
    endfunction

    function automatic tdr_result_t ring_update(int cp, ring_req_t rq);
        tdr_result_t r;
        logic [6:0]  nxt;
        r = '0;
        r.status = ST_NOTHING;
        case (rq.action)
            ACT_SUBMIT:
            begin
                nxt = slot_after(ring_tail[cp]);
                if (nxt == ring_head[cp])
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    r.status = ST_ACCEPTED;
                    r.slot = ring_tail[cp];
                    r.desc_address = rq.buffer_address;
                    r.desc_length = rq.frame_length;
                    r.desc_command = DESC_CMD;
                    ring_tag[cp][ring_tail[cp]] = rq.buffer_tag;
                    ring_busy[cp][ring_tail[cp]] = 1'b1;
                    ring_done[cp][ring_tail[cp]] = 1'b0;
                    ring_tail[cp] = nxt;
                end
            end
            ACT_MARK_DONE:
            begin
                r.status = ST_DONE;
                r.slot = rq.done_slot;
                if (int'(rq.done_slot) < RING_DEPTH)
                    ring_done[cp][rq.done_slot] = 1'b1;
            end
            ACT_RECLAIM:
            begin
                nxt = slot_after(ring_head[cp]);
                if (ring_done[cp][nxt])
                begin
                    r.status = ST_RECLAIM;
                    r.slot = nxt;
                    ring_head[cp] = nxt;
                    if (ring_busy[cp][nxt])
                    begin
                        r.freed_tag = ring_tag[cp][nxt];
                        r.freed_tag_valid = 1'b1;
                    end
                    ring_busy[cp][nxt] = 1'b0;
                    ring_done[cp][nxt] = 1'b0;
                end
            end
            default: ;
        endcase
        r.tail_index = ring_tail[cp];
        r.head_index = ring_head[cp];
        r.more_ready = ring_done[cp][slot_after(ring_head[cp])];
        return r;
    endfunction

    function automatic ring_req_t random_req(logic [1:0] act);
        ring_req_t rq;
        rq.action = act;
        rq.buffer_address = $urandom;
        rq.frame_length = 16'($urandom_range(0, 65535));
        rq.buffer_tag = 16'($urandom_range(0, 65535));
        rq.done_slot = 7'($urandom_range(0, RING_DEPTH - 1));
        return rq;
    endfunction

    task automatic push_req(ring_req_t rq);
        ring_requests.push_back(rq);
        void'(ring_update(GEN_COPY, rq));
        if (rq.action != ACT_UNUSED)
            gen_items++;
    endtask

    task automatic push_random(logic [1:0] act);
        push_req(random_req(act));
    endtask

    task automatic push_mark(logic [6:0] s);
        ring_req_t rq;
        rq = random_req(ACT_MARK_DONE);
        rq.done_slot = s;
        push_req(rq);
    endtask

    // Complete one in-flight slot near the head, possibly out of order
    task automatic mark_in_flight();
        logic [6:0] picks[$];
        logic [6:0] s;
        s = slot_after(ring_head[GEN_COPY]);
        for (int k = 0; k < 16; k++)
        begin
            if (ring_busy[GEN_COPY][s] && !ring_done[GEN_COPY][s])
                picks.push_back(s);
            s = slot_after(s);
        end
        if (picks.size() == 0)
            push_mark(slot_after(ring_head[GEN_COPY]));
        else
            push_mark(picks[$urandom_range(0, picks.size() - 1)]);
    endtask

    task automatic fill_and_drain();
        int guard;
        guard = 0;
        while (slot_after(ring_tail[GEN_COPY]) != ring_head[GEN_COPY] && guard < 2 * RING_DEPTH)
        begin
            push_random(ACT_SUBMIT);
            guard++;
        end
        // Rejected while full, then free one slot and refill it
        repeat (2) push_random(ACT_SUBMIT);
        push_mark(slot_after(ring_head[GEN_COPY]));
        push_random(ACT_RECLAIM);
        repeat (2) push_random(ACT_SUBMIT);
        guard = 0;
        while (slot_after(ring_head[GEN_COPY]) != ring_tail[GEN_COPY] && guard < 2 * RING_DEPTH)
        begin
            push_mark(slot_after(ring_head[GEN_COPY]));
            push_random(ACT_RECLAIM);
            guard++;
        end
        fills++;
    endtask

    task automatic report_error(string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] exp);
        if (got !== exp)
            report_error($sformatf("response %0d %s: got %0h expected %0h",
                                   rsp_accepted, name, got, exp));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL tx_descriptor_ring");
            $finish;
        end
    end

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (drv_valid && req_ch.ready)
            begin
                responses_due.push_back(ring_update(CHK_COPY, drv_req));
                req_accepted++;
            end
            if (!drv_valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end
                else if (ring_requests.size() != 0)
                begin
                    drv_req <= ring_requests.pop_front();
                    drv_valid <= 1'b1;
                    if (ring_requests.size() > QUIET_TAIL && (req_accepted / 128) % 2 == 0
                        && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    always @(posedge clk)
    begin : rsp_monitor
        tdr_result_t exp;
        if (!rst_n)
        begin
            drv_ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && drv_ready)
            begin
                if (responses_due.size() == 0)
                begin
                    report_error($sformatf("response %0d with no request outstanding",
                                           rsp_accepted));
                end
                else
                begin
                    exp = responses_due.pop_front();
                    compare_field("status", 32'(rsp_ch.status), 32'(exp.status));
                    compare_field("slot", 32'(rsp_ch.slot), 32'(exp.slot));
                    compare_field("desc_address", rsp_ch.desc_address, exp.desc_address);
                    compare_field("desc_length", 32'(rsp_ch.desc_length), 32'(exp.desc_length));
                    compare_field("desc_command", 32'(rsp_ch.desc_command),
                                  32'(exp.desc_command));
                    compare_field("tail_index", 32'(rsp_ch.tail_index), 32'(exp.tail_index));
                    compare_field("head_index", 32'(rsp_ch.head_index), 32'(exp.head_index));
                    compare_field("freed_tag", 32'(rsp_ch.freed_tag), 32'(exp.freed_tag));
                    compare_field("freed_tag_valid", 32'(rsp_ch.freed_tag_valid),
                                  32'(exp.freed_tag_valid));
                    compare_field("more_ready", 32'(rsp_ch.more_ready), 32'(exp.more_ready));
                end
                rsp_accepted++;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                drv_ready <= 1'b0;
            end
            else if (ring_requests.size() > QUIET_TAIL && (rsp_accepted / 96) % 3 != 2
                     && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                drv_ready <= 1'b0;
            end
            else
            begin
                drv_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int pick;
        int n;
        for (int cp = 0; cp < 2; cp++)
        begin
            ring_head[cp] = 7'(RING_DEPTH - 1);
            ring_tail[cp] = 7'd0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_tag[cp][i] = 16'd0;
                ring_busy[cp][i] = 1'b0;
                ring_done[cp][i] = 1'b0;
            end
        end

        // Directed: field extremes, empty reclaim, unused action,
        // done bits on slots not yet submitted, and head moving past tail
        push_req(ring_req_t'{ACT_SUBMIT, 32'h0, 16'h0, 16'h0, 7'h0});
        push_req(ring_req_t'{ACT_SUBMIT, '1, '1, '1, '1});
        push_req(ring_req_t'{ACT_RECLAIM, 32'h0, 16'h0, 16'h0, 7'h0});
        push_req(ring_req_t'{ACT_UNUSED, '1, '1, '1, '1});
        push_req(ring_req_t'{ACT_MARK_DONE, 32'h0, 16'h0, 16'h0, 7'h0});
        push_req(ring_req_t'{ACT_RECLAIM, '1, '1, '1, '1});
        push_mark(7'd1);
        push_random(ACT_RECLAIM);
        push_mark(7'd2);
        push_random(ACT_SUBMIT);
        push_random(ACT_RECLAIM);
        push_mark(7'd3);
        push_mark(7'd2);
        push_random(ACT_RECLAIM);
        push_random(ACT_RECLAIM);
        push_req(ring_req_t'{ACT_MARK_DONE, 32'h0, 16'h0, 16'h0, 7'h7f});
        push_random(ACT_RECLAIM);
        push_random(ACT_UNUSED);

        fill_and_drain();
        while (gen_items < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                n = $urandom_range(1, 8);
                repeat (n) push_random(ACT_SUBMIT);
                repeat ($urandom_range(0, n)) mark_in_flight();
                repeat ($urandom_range(0, n + 1)) push_random(ACT_RECLAIM);
            end
            else if (pick < 62)
            begin
                repeat ($urandom_range(1, 4)) mark_in_flight();
                push_random(ACT_RECLAIM);
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4)) push_random(2'($urandom_range(0, 3)));
            end
            else if (pick < 82 && fills < MAX_FILLS)
            begin
                fill_and_drain();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_mark(slot_after(ring_head[GEN_COPY]));
                    push_random(ACT_RECLAIM);
                end
            end
        end
        req_total = ring_requests.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (req_accepted < req_total)
            @(posedge clk);
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("PASS tx_descriptor_ring");
        else
            $display("FAIL tx_descriptor_ring");
        $finish;
    end

endmodule
